[hw/rtl/dstk_pkg.sv]
// dstk_pkg: shared types and constants for the deduplicating event stack.
// No dependencies.
package dstk_pkg;

    localparam int REC_W = 24;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DUP     = 3'd1,
        ST_DROPPED = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

endpackage

[hw/rtl/dstk_ram.sv]
// dstk_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dstk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/dedup_event_stack_unit.sv]
// dedup_event_stack_unit: deduplicating LIFO event store, oldest dropped when full.
// Depends on dstk_pkg and dstk_ram.
//
//  channel | handshake           | fields
//  in      | in_valid / in_ready   | operation, event_kind, event_source, event_location
//  out     | out_valid / out_ready | status, out_kind, out_source, out_location, entry_count
//
// Push: one RAM read per live entry, with a pipelined compare.
// Pop: one RAM read of the top entry; no read on an empty store.
// Entries live in a circular buffer; dropping the oldest moves the base pointer.
// Reset clears state, count, base, scan control and output valid; RAM contents are never read before written.
// A new request is taken while a result waits; it completes once the output is free.
module dedup_event_stack_unit
    import dstk_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] event_kind,
    input  logic [7:0] event_source,
    input  logic [7:0] event_location,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] out_kind,
    output logic [7:0] out_source,
    output logic [7:0] out_location,
    output logic [3:0] entry_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_POPRD  = 5'b00100,
        S_POPDAT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = s - SUM_W'(DEPTH);
        if (s >= SUM_W'(DEPTH))
        begin
            return d[PTR_W-1:0];
        end
        return s[PTR_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [REC_W-1:0]   rec_reg, rec_next;
    logic [PTR_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   iss_cnt_reg, iss_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               dup_reg, dup_next;
    status_t            res_status_reg, res_status_next;
    logic [REC_W-1:0]   res_rec_reg, res_rec_next;
    logic [CNT_W-1:0]   res_count_reg, res_count_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [REC_W-1:0]   out_rec_reg, out_rec_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_wr_addr;
    logic               ram_rd_en;
    logic [REC_W-1:0]   ram_rd_data;
    logic               issue;
    logic               hit;
    logic [CNT_W+3:0]   count_ext;

    dstk_ram #(
        .WIDTH(REC_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (rec_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign issue = (iss_cnt_reg != count_reg);
    assign hit   = cmp_vld_reg && (ram_rd_data == rec_reg);

    always_comb
    begin
        state_next      = state_reg;
        rec_next        = rec_reg;
        base_next       = base_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        iss_cnt_next    = iss_cnt_reg;
        cmp_vld_next    = 1'b0;
        dup_next        = dup_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = base_reg;
        ram_rd_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rec_next = {event_kind, event_source, event_location};
                    if (!operation)
                    begin
                        rd_ptr_next  = base_reg;
                        iss_cnt_next = '0;
                        dup_next     = 1'b0;
                        state_next   = S_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        res_rec_next    = '0;
                        res_count_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_ptr_next = wrap_idx(SUM_W'(base_reg) + SUM_W'(count_reg)
                                               - SUM_W'(1));
                        count_next  = count_reg - CNT_W'(1);
                        state_next  = S_POPRD;
                    end
                end
            end
            S_SCAN:
            begin
                // reads issued back to back; each compare follows in the cycle after its read
                if (issue)
                begin
                    ram_rd_en    = 1'b1;
                    rd_ptr_next  = wrap_idx(SUM_W'(rd_ptr_reg) + SUM_W'(1));
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                end
                cmp_vld_next = issue;
                dup_next     = dup_reg || hit;
                if (!issue && !cmp_vld_reg)
                begin
                    res_rec_next = '0;
                    state_next   = S_DONE;
                    if (dup_reg)
                    begin
                        res_status_next = ST_DUP;
                        res_count_next  = count_reg;
                    end
                    else if (count_reg != CNT_W'(DEPTH))
                    begin
                        ram_we          = 1'b1;
                        ram_wr_addr     = wrap_idx(SUM_W'(base_reg) + SUM_W'(count_reg));
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_STORED;
                        res_count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // overwrite oldest slot, which becomes the top
                        ram_we          = 1'b1;
                        ram_wr_addr     = base_reg;
                        base_next       = wrap_idx(SUM_W'(base_reg) + SUM_W'(1));
                        res_status_next = ST_DROPPED;
                        res_count_next  = count_reg;
                    end
                end
            end
            S_POPRD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_POPDAT;
            end
            S_POPDAT:
            begin
                res_status_next = ST_POPPED;
                res_rec_next    = ram_rd_data;
                res_count_next  = count_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rec_next    = res_rec_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            iss_cnt_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            iss_cnt_reg   <= iss_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg        <= rec_next;
        rd_ptr_reg     <= rd_ptr_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_rec_reg    <= out_rec_next;
        out_count_reg  <= out_count_next;
    end

    assign count_ext    = {4'b0000, out_count_reg};
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_kind     = out_rec_reg[23:16];
    assign out_source   = out_rec_reg[15:8];
    assign out_location = out_rec_reg[7:0];
    assign entry_count  = count_ext[3:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("live count above depth");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN) && !issue && !cmp_vld_reg && !dup_reg)
        else $error("store written outside end of scan");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement count");

    a_base_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(base_reg) |-> ($past(count_reg) == CNT_W'(DEPTH)))
        else $error("base moved while not full");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (iss_cnt_reg <= count_reg))
        else $error("scan issued past live entries");
`endif

endmodule
